/* rtl/clcur_pkg.sv */
// Shared constants for the circular list block: command and status codes,
// field widths and the default pool size. No dependencies.
package clcur_pkg;

   localparam int CLCUR_CAPACITY = 256;

   localparam int CMD_W  = 3;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [STAT_W-1:0] status_type;

   localparam cmd_type CMD_INS_TAIL = 3'd0;
   localparam cmd_type CMD_INS_HEAD = 3'd1;
   localparam cmd_type CMD_FIRST    = 3'd2;
   localparam cmd_type CMD_NEXT     = 3'd3;
   localparam cmd_type CMD_REMOVE   = 3'd4;
   localparam cmd_type CMD_LENGTH   = 3'd5;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_NOCUR = 2'd3;

endpackage

/* rtl/clcur_ram.sv */
// Simple dual-port node memory: one write port, one read port, registered read.
// No dependencies; used for the node value and node link arrays.
module clcur_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read during write to the same address returns the old contents
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/circular_list_with_cursor.sv */
// Circular singly linked list with cursor, kept in two node memories.
// Per command: length/errors end in S_START; first/next pass S_WALK1, S_WALK2; remove
// S_REM1, S_REM2 (not on a ring drop); inserts S_ALLOC for a free-list node, then S_INS2,
// S_INS3 (not into an empty list). One command at a time, set by the single read and
// write port of the link memory. A new item is taken while a result waits.
// Reset (synchronous): empty list, no cursor, fresh pool; node memories need no clearing.
module circular_list_with_cursor
   import clcur_pkg::*;
#(
   parameter int CAPACITY = CLCUR_CAPACITY
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [2:0] command, [34:3] value_in, rest zero
   input  logic [((CMD_W + VAL_W + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [1:0] status, [33:2] value_out, then length, rest zero
   output logic [((STAT_W + VAL_W + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int PW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int RSP_W = ((STAT_W + VAL_W + CW + 7) / 8) * 8;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_ALLOC = 4'd2;
   localparam logic [3:0] S_INS2  = 4'd3;
   localparam logic [3:0] S_INS3  = 4'd4;
   localparam logic [3:0] S_WALK1 = 4'd5;
   localparam logic [3:0] S_WALK2 = 4'd6;
   localparam logic [3:0] S_REM1  = 4'd7;
   localparam logic [3:0] S_REM2  = 4'd8;

   logic [3:0]       state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [PW-1:0]    cursor_ff, cursor_in;
   logic [PW-1:0]    before_ff, before_in;
   logic             cvalid_ff, cvalid_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [PW-1:0]    free_head_ff, free_head_in;
   logic [CW-1:0]    free_count_ff, free_count_in;
   logic [CW-1:0]    fresh_ff, fresh_in;
   logic [PW-1:0]    node_ff, node_in;
   logic [VAL_W-1:0] vout_ff, vout_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CW-1:0]    rsp_length_ff, rsp_length_in;

   logic             lk_we;
   logic [PW-1:0]    lk_waddr, lk_wdata, lk_raddr, lk_rdata;
   logic             vl_we;
   logic [PW-1:0]    vl_waddr, vl_raddr;
   logic [VAL_W-1:0] vl_wdata, vl_rdata;

   logic             done;
   status_type       done_status;
   logic [VAL_W-1:0] done_value;
   logic             go;
   logic             use_free;
   logic             full;
   logic [PW-1:0]    new_node;
   logic [PW-1:0]    walk_base;

   clcur_ram #(.DEPTH(CAPACITY), .WIDTH(PW)) u_link_ram (
      .clock   (clock),
      .wr_en   (lk_we),
      .wr_addr (lk_waddr),
      .wr_data (lk_wdata),
      .rd_addr (lk_raddr),
      .rd_data (lk_rdata)
   );

   clcur_ram #(.DEPTH(CAPACITY), .WIDTH(VAL_W)) u_value_ram (
      .clock   (clock),
      .wr_en   (vl_we),
      .wr_addr (vl_waddr),
      .wr_data (vl_wdata),
      .rd_addr (vl_raddr),
      .rd_data (vl_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_length_ff, rsp_value_ff, rsp_status_ff});

   assign go       = !rsp_valid_ff || rsp_tready;
   assign use_free = (free_count_ff != '0);
   // pool can run dry below capacity once a remove has dropped a ring
   assign full     = (count_ff == CW'(CAPACITY)) ||
                     (!use_free && (fresh_ff == CW'(CAPACITY)));
   assign new_node = use_free ? free_head_ff : fresh_ff[PW-1:0];
   assign walk_base = (cmd_ff == CMD_FIRST) ? tail_ff : cursor_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      tail_in       = tail_ff;
      cursor_in     = cursor_ff;
      before_in     = before_ff;
      cvalid_in     = cvalid_ff;
      count_in      = count_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      fresh_in      = fresh_ff;
      node_in       = node_ff;
      vout_in       = vout_ff;

      lk_we    = 1'b0;
      lk_waddr = node_ff;
      lk_wdata = node_ff;
      lk_raddr = tail_ff;
      vl_we    = 1'b0;
      vl_waddr = new_node;
      vl_wdata = val_ff;
      vl_raddr = cursor_ff;

      done        = 1'b0;
      done_status = ST_OK;
      done_value  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tdata[CMD_W-1:0];
               val_in   = req_tdata[CMD_W+VAL_W-1:CMD_W];
               state_in = S_START;
            end
         end
         S_START: begin
            if (go) begin
               unique case (cmd_ff)
                  CMD_INS_TAIL, CMD_INS_HEAD: begin
                     if (full) begin
                        done        = 1'b1;
                        done_status = ST_FULL;
                        state_in    = S_IDLE;
                     end else begin
                        node_in  = new_node;
                        vl_we    = 1'b1;
                        if (use_free) begin
                           free_count_in = free_count_ff - 1'b1;
                           lk_raddr      = free_head_ff;
                           state_in      = S_ALLOC;
                        end else begin
                           fresh_in = fresh_ff + 1'b1;
                           if (count_ff == '0) begin
                              lk_we    = 1'b1;
                              lk_waddr = new_node;
                              lk_wdata = new_node;
                              tail_in  = new_node;
                              count_in = count_ff + 1'b1;
                              done     = 1'b1;
                              state_in = S_IDLE;
                           end else begin
                              lk_raddr = tail_ff;
                              state_in = S_INS2;
                           end
                        end
                     end
                  end
                  CMD_FIRST, CMD_NEXT: begin
                     if (count_ff == '0) begin
                        done        = 1'b1;
                        done_status = ST_EMPTY;
                        state_in    = S_IDLE;
                     end else if (cmd_ff == CMD_NEXT && !cvalid_ff) begin
                        done        = 1'b1;
                        done_status = ST_NOCUR;
                        state_in    = S_IDLE;
                     end else begin
                        before_in = walk_base;
                        lk_raddr  = walk_base;
                        state_in  = S_WALK1;
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        done        = 1'b1;
                        done_status = ST_EMPTY;
                        state_in    = S_IDLE;
                     end else if (!cvalid_ff) begin
                        done        = 1'b1;
                        done_status = ST_NOCUR;
                        state_in    = S_IDLE;
                     end else begin
                        lk_raddr = cursor_ff;
                        vl_raddr = cursor_ff;
                        state_in = S_REM1;
                     end
                  end
                  default: begin
                     // length query and unused codes
                     done     = 1'b1;
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            // lk_rdata is the next free node after the one taken
            free_head_in = lk_rdata;
            if (count_ff == '0) begin
               lk_we    = 1'b1;
               lk_waddr = node_ff;
               lk_wdata = node_ff;
               tail_in  = node_ff;
               count_in = count_ff + 1'b1;
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               lk_raddr = tail_ff;
               state_in = S_INS2;
            end
         end
         S_INS2: begin
            // new node points at the old first element
            lk_we    = 1'b1;
            lk_waddr = node_ff;
            lk_wdata = lk_rdata;
            state_in = S_INS3;
         end
         S_INS3: begin
            lk_we    = 1'b1;
            lk_waddr = tail_ff;
            lk_wdata = node_ff;
            if (cvalid_ff && before_ff == tail_ff) begin
               before_in = node_ff;
            end
            if (cmd_ff == CMD_INS_TAIL) begin
               tail_in = node_ff;
            end
            count_in = count_ff + 1'b1;
            done     = 1'b1;
            state_in = S_IDLE;
         end
         S_WALK1: begin
            cursor_in = lk_rdata;
            cvalid_in = 1'b1;
            vl_raddr  = lk_rdata;
            state_in  = S_WALK2;
         end
         S_WALK2: begin
            done       = 1'b1;
            done_value = vl_rdata;
            state_in   = S_IDLE;
         end
         S_REM1: begin
            vout_in = vl_rdata;
            if (count_ff == CW'(1) || cursor_ff == before_ff) begin
               // whole ring dropped; only the cursor node returns to the pool
               lk_we         = 1'b1;
               lk_waddr      = cursor_ff;
               lk_wdata      = free_head_ff;
               free_head_in  = cursor_ff;
               free_count_in = free_count_ff + 1'b1;
               cursor_in     = '0;
               before_in     = '0;
               tail_in       = '0;
               cvalid_in     = 1'b0;
               count_in      = '0;
               done          = 1'b1;
               done_value    = vl_rdata;
               state_in      = S_IDLE;
            end else begin
               lk_we    = 1'b1;
               lk_waddr = before_ff;
               lk_wdata = lk_rdata;
               if (cursor_ff == tail_ff) begin
                  tail_in = before_ff;
               end
               state_in = S_REM2;
            end
         end
         S_REM2: begin
            lk_we         = 1'b1;
            lk_waddr      = cursor_ff;
            lk_wdata      = free_head_ff;
            free_head_in  = cursor_ff;
            free_count_in = free_count_ff + 1'b1;
            cursor_in     = before_ff;
            count_in      = count_ff - 1'b1;
            done          = 1'b1;
            done_value    = vout_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_length_in = rsp_length_ff;
      if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = done_status;
         rsp_value_in  = done_value;
         rsp_length_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tail_ff       <= '0;
         cursor_ff     <= '0;
         before_ff     <= '0;
         cvalid_ff     <= 1'b0;
         count_ff      <= '0;
         free_head_ff  <= '0;
         free_count_ff <= '0;
         fresh_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tail_ff       <= tail_in;
         cursor_ff     <= cursor_in;
         before_ff     <= before_in;
         cvalid_ff     <= cvalid_in;
         count_ff      <= count_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         fresh_ff      <= fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      node_ff       <= node_in;
      vout_ff       <= vout_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_length_ff <= rsp_length_in;
   end

endmodule

/* test/circular_list_with_cursor_tb.sv */
// Self-checking bench for circular_list_with_cursor: streams list commands, predicts each
// response with a behavioral list/pool model and checks responses in order.
// Depends on clcur_pkg and the circular_list_with_cursor RTL.
`timescale 1ns / 1ps

module circular_list_with_cursor_tb;
   import clcur_pkg::*;

   localparam int CAP       = CLCUR_CAPACITY;
   localparam int IDX_W     = $clog2(CAP);
   localparam int LEN_W     = $clog2(CAP + 1);
   localparam int REQ_W     = ((CMD_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_W     = ((STAT_W + VAL_W + LEN_W + 7) / 8) * 8;
   localparam int N_RANDOM  = 760;
   localparam int N_FILL    = 262;
   localparam int IDLE_MAX  = 3000;

   typedef struct {
      cmd_type                   cmd;
      logic signed [VAL_W-1:0]   val;
      bit                        drain;  // hold until every response is back
   } list_cmd_t;

   typedef struct {
      status_type                status;
      logic signed [VAL_W-1:0]   value;
      logic [LEN_W-1:0]          length;
   } list_rsp_t;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // [2:0] command, [34:3] value_in, rest zero
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // [1:0] status, [33:2] value_out, [42:34] length, rest zero
   logic [RSP_W-1:0] rsp_tdata;

   list_cmd_t   cmd_backlog[$];
   list_rsp_t   pending_rsp[$];
   int unsigned sent_total = 0;
   int unsigned done_total = 0;
   int unsigned mismatch_cnt = 0;

   // behavioral copy of the list and node pool
   logic [VAL_W-1:0] node_val  [CAP];
   logic [IDX_W-1:0] node_nxt  [CAP];
   logic [IDX_W-1:0] tail_idx = '0;
   logic [IDX_W-1:0] cur_idx  = '0;
   logic [IDX_W-1:0] prev_idx = '0;
   logic             cur_ok   = 1'b0;
   logic [LEN_W-1:0] elem_cnt = '0;
   logic [IDX_W-1:0] free_top = '0;
   logic [LEN_W-1:0] free_cnt = '0;
   logic [IDX_W:0]   fresh_idx = '0;

   circular_list_with_cursor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic list_rsp_t list_apply(cmd_type cmd, logic [VAL_W-1:0] val);
      list_rsp_t        r;
      logic [IDX_W-1:0] n;
      logic [IDX_W-1:0] c;
      logic [IDX_W-1:0] b;
      logic             got;
      r.status = ST_OK;
      r.value  = '0;
      n   = '0;
      got = 1'b0;
      case (cmd)
         CMD_INS_TAIL, CMD_INS_HEAD: begin
            if (elem_cnt < CAP) begin
               // recycled nodes first, then never-used ones
               if (free_cnt != 0) begin
                  n        = free_top;
                  free_top = node_nxt[n];
                  free_cnt = free_cnt - 1'b1;
                  got      = 1'b1;
               end else if (fresh_idx < CAP) begin
                  n         = fresh_idx[IDX_W-1:0];
                  fresh_idx = fresh_idx + 1'b1;
                  got       = 1'b1;
               end
            end
            if (!got) begin
               r.status = ST_FULL;
            end else begin
               node_val[n] = val;
               if (elem_cnt == 0) begin
                  node_nxt[n] = n;
                  tail_idx    = n;
               end else begin
                  node_nxt[n]        = node_nxt[tail_idx];
                  node_nxt[tail_idx] = n;
                  if (cur_ok && prev_idx == tail_idx)
                     prev_idx = n;
                  if (cmd == CMD_INS_TAIL)
                     tail_idx = n;
               end
               elem_cnt = elem_cnt + 1'b1;
            end
         end
         CMD_FIRST: begin
            if (elem_cnt == 0) begin
               r.status = ST_EMPTY;
            end else begin
               prev_idx = tail_idx;
               cur_idx  = node_nxt[prev_idx];
               cur_ok   = 1'b1;
               r.value  = node_val[cur_idx];
            end
         end
         CMD_NEXT: begin
            if (elem_cnt == 0) begin
               r.status = ST_EMPTY;
            end else if (!cur_ok) begin
               r.status = ST_NOCUR;
            end else begin
               prev_idx = cur_idx;
               cur_idx  = node_nxt[prev_idx];
               r.value  = node_val[cur_idx];
            end
         end
         CMD_REMOVE: begin
            if (elem_cnt == 0) begin
               r.status = ST_EMPTY;
            end else if (!cur_ok) begin
               r.status = ST_NOCUR;
            end else begin
               c       = cur_idx;
               b       = prev_idx;
               r.value = node_val[c];
               if (elem_cnt == 1 || c == b) begin
                  // whole list dropped; only the cursor node goes back to the pool
                  node_nxt[c] = free_top;
                  free_top    = c;
                  free_cnt    = free_cnt + 1'b1;
                  cur_idx     = '0;
                  prev_idx    = '0;
                  tail_idx    = '0;
                  cur_ok      = 1'b0;
                  elem_cnt    = '0;
               end else begin
                  if (c == tail_idx)
                     tail_idx = b;
                  node_nxt[b] = node_nxt[c];
                  node_nxt[c] = free_top;
                  free_top    = c;
                  free_cnt    = free_cnt + 1'b1;
                  cur_idx     = b;
                  elem_cnt    = elem_cnt - 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.length = elem_cnt;
      return r;
   endfunction

   function automatic void add_cmd(cmd_type cmd, logic [VAL_W-1:0] val, bit drain = 1'b0);
      list_cmd_t it;
      it.cmd   = cmd;
      it.val   = val;
      it.drain = drain;
      cmd_backlog.push_back(it);
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic void note_mismatch(string msg);
      if (mismatch_cnt < 10)
         $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_cnt++;
   endfunction

   // ---------------- sender ----------------
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      list_cmd_t   head_item;
      logic        took;
      logic        offer;
      int unsigned sent_so_far;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         took = req_tvalid && req_tready;
         if (took) begin
            head_item = cmd_backlog.pop_front();
            pending_rsp.push_back(list_apply(head_item.cmd, head_item.val));
            sent_total <= sent_total + 1;
         end
         sent_so_far = sent_total + (took ? 1 : 0);
         offer = 1'b0;
         if (req_tvalid && !took) begin
            offer = 1'b1;
         end else if (cmd_backlog.size() == 0) begin
            offer = 1'b0;
         end else if (cmd_backlog[0].drain && sent_so_far != done_total) begin
            offer = 1'b0;
         end else if (gap_left != 0) begin
            gap_left--;
         end else begin
            offer = 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               if ($urandom_range(0, 7) == 0) begin
                  burst_left = $urandom_range(40, 120);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = $urandom_range(0, 6);
               end
            end
         end
         req_tvalid <= offer;
         if (offer)
            req_tdata <= {{(REQ_W - CMD_W - VAL_W){1'b0}}, cmd_backlog[0].val,
                          cmd_backlog[0].cmd};
      end
   end

   // ---------------- receiver and checker ----------------
   int unsigned hold_left = 0;
   bit          long_hold_done = 1'b0;
   int unsigned stretch_left = 0;
   int unsigned ready_pct = 100;

   always @(posedge clock) begin
      list_rsp_t               want;
      status_type              got_status;
      logic signed [VAL_W-1:0] got_value;
      logic [LEN_W-1:0]        got_len;
      logic                    ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_status = rsp_tdata[STAT_W-1:0];
            got_value  = rsp_tdata[STAT_W +: VAL_W];
            got_len    = rsp_tdata[STAT_W + VAL_W +: LEN_W];
            done_total <= done_total + 1;
            if (pending_rsp.size() == 0) begin
               note_mismatch($sformatf("response with nothing pending: status %0d value %h length %0d",
                                       got_status, got_value, got_len));
            end else begin
               want = pending_rsp.pop_front();
               if (got_status !== want.status || got_value !== want.value ||
                   got_len !== want.length)
                  note_mismatch($sformatf(
                     "item %0d: status exp %0d got %0d, value exp %h got %h, length exp %0d got %0d",
                     done_total, want.status, got_status, want.value, got_value,
                     want.length, got_len));
            end
         end
         // one long hold-off so the block backs up into the request side
         if (!long_hold_done && done_total == 400) begin
            hold_left      = 500;
            long_hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(20, 120);
               case ($urandom_range(0, 3))
                  0:       ready_pct = 100;
                  1:       ready_pct = 70;
                  2:       ready_pct = 40;
                  default: ready_pct = 15;
               endcase
            end
            stretch_left--;
            ready_next = ($urandom_range(0, 99) < ready_pct);
         end
         rsp_tready <= ready_next;
      end
   end

   // ---------------- watchdog ----------------
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_MAX) begin
            $display("timeout: no item moved for %0d cycles", IDLE_MAX);
            $display("circular_list_with_cursor_tb NOT OK");
            $finish;
         end
      end
   end

   // ---------------- stimulus and end of run ----------------
   initial begin
      int unsigned ins_pct;
      int unsigned r;
      cmd_type     c;
      bit          after_remove;

      // directed: empty list, missing cursor, single element, insert ahead of cursor
      add_cmd(CMD_LENGTH, 32'h0);
      add_cmd(CMD_FIRST, 32'h0);
      add_cmd(CMD_NEXT, 32'h0);
      add_cmd(CMD_REMOVE, 32'h0);
      add_cmd(CMD_INS_TAIL, 32'h7fff_ffff);
      add_cmd(CMD_NEXT, 32'h0);
      add_cmd(CMD_REMOVE, 32'h0);
      add_cmd(CMD_FIRST, 32'h0);
      add_cmd(CMD_REMOVE, 32'h0);           // only element goes, cursor cleared
      add_cmd(CMD_NEXT, 32'h0);
      add_cmd(CMD_INS_HEAD, 32'h8000_0000);
      add_cmd(CMD_INS_TAIL, 32'hffff_ffff);
      add_cmd(CMD_INS_TAIL, 32'h0000_0000);
      add_cmd(CMD_NEXT, 32'h0);
      add_cmd(CMD_FIRST, 32'h0);
      add_cmd(CMD_INS_HEAD, 32'h5555_5555); // predecessor was the tail
      add_cmd(CMD_NEXT, 32'h0);
      add_cmd(CMD_REMOVE, 32'h0);
      add_cmd(CMD_NEXT, 32'h0);
      add_cmd(CMD_INS_TAIL, 32'haaaa_aaaa);
      add_cmd(cmd_type'(6), 32'h1234_5678);
      add_cmd(cmd_type'(7), 32'hedcb_a987);
      add_cmd(CMD_FIRST, 32'h0);
      add_cmd(CMD_REMOVE, 32'h0);
      add_cmd(CMD_LENGTH, 32'hffff_ffff);

      // random part in segments that grow or shrink the list
      after_remove = 1'b0;
      ins_pct      = 35;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 60 == 0) begin
            case ($urandom_range(0, 2))
               0:       ins_pct = 15;
               1:       ins_pct = 35;
               default: ins_pct = 55;
            endcase
         end
         if ($urandom_range(0, 99) < ins_pct) begin
            c = $urandom_range(0, 1) ? CMD_INS_TAIL : CMD_INS_HEAD;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 12)      c = CMD_FIRST;
            else if (r < 55) c = CMD_NEXT;
            else if (r < 85) c = CMD_REMOVE;
            else if (r < 93) c = CMD_LENGTH;
            else             c = cmd_type'($urandom_range(6, 7));
         end
         // back-to-back removes drop the whole ring; keep that for the end
         if (c == CMD_REMOVE && after_remove)
            c = CMD_NEXT;
         if (c == CMD_REMOVE)
            after_remove = 1'b1;
         else if (c == CMD_FIRST || c == CMD_NEXT)
            after_remove = 1'b0;
         add_cmd(c, pick_value(), i == 300);
      end

      // fill the pool to capacity and push past it
      for (int i = 0; i < N_FILL; i++)
         add_cmd($urandom_range(0, 1) ? CMD_INS_TAIL : CMD_INS_HEAD, pick_value(), i == 0);

      // remove twice without moving: cursor equals predecessor, ring is dropped
      add_cmd(CMD_FIRST, 32'h0);
      add_cmd(CMD_NEXT, 32'h0);
      add_cmd(CMD_REMOVE, 32'h0);
      add_cmd(CMD_REMOVE, 32'h0);
      add_cmd(CMD_LENGTH, 32'h0);
      add_cmd(CMD_INS_HEAD, pick_value());
      add_cmd(CMD_INS_TAIL, pick_value());
      add_cmd(CMD_FIRST, 32'h0);
      add_cmd(CMD_NEXT, 32'h0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || sent_total != done_total)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (pending_rsp.size() != 0)
         $display("%0d responses never arrived", pending_rsp.size());
      if (mismatch_cnt == 0 && pending_rsp.size() == 0)
         $display("circular_list_with_cursor_tb OK");
      else
         $display("circular_list_with_cursor_tb NOT OK");
      $finish;
   end

endmodule

/* filelist.f */
rtl/clcur_pkg.sv
rtl/clcur_ram.sv
rtl/circular_list_with_cursor.sv
test/circular_list_with_cursor_tb.sv
